FILE: hdl/ipke_pkg.sv
package ipke_pkg;

   // field widths
   localparam int DATA_W  = 8;
   localparam int COUNT_W = 6;
   localparam int VER_W   = 4;
   localparam int ADDR_BYTES = 16;
   localparam int INDEX_W = 4;
   localparam int KEY_W   = 64;

   // packet layout
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 6'd63;
   localparam logic [COUNT_W-1:0] V4_MIN_BYTES = 6'd20;
   localparam logic [COUNT_W-1:0] V6_MIN_BYTES = 6'd40;
   localparam logic [COUNT_W-1:0] V4_SRC_OFF   = 6'd12;
   localparam logic [COUNT_W-1:0] V4_DST_OFF   = 6'd16;
   localparam logic [COUNT_W-1:0] V6_SRC_OFF   = 6'd8;
   localparam logic [COUNT_W-1:0] V6_DST_OFF   = 6'd24;
   localparam logic [COUNT_W-1:0] V4_ADDR_LEN  = 6'd4;
   localparam logic [COUNT_W-1:0] V6_ADDR_LEN  = 6'd16;
   localparam logic [VER_W-1:0]   VERSION_4    = 4'd4;
   localparam logic [VER_W-1:0]   VERSION_6    = 4'd6;
   localparam logic [3:0]         V4_MCAST_NIB = 4'hE;
   localparam logic [DATA_W-1:0]  V6_MCAST_BYTE = 8'hFF;

   typedef enum logic [2:0] {
      REASON_OK          = 3'd0,
      REASON_TOO_SHORT   = 3'd1,
      REASON_BAD_HDR_LEN = 3'd2,
      REASON_UNSPEC      = 3'd3,
      REASON_MULTICAST   = 3'd4,
      REASON_BAD_VERSION = 3'd5
   } reason_type;

   // packet state as it stands after the current word
   typedef struct packed {
      logic [COUNT_W-1:0]           count;
      logic [VER_W-1:0]             version;
      logic [COUNT_W-1:0]           hdr_bytes;
      logic [ADDR_BYTES*DATA_W-1:0] addr;   // address byte 0 in the top bits
   } pkt_view_type;

   typedef struct packed {
      logic       key_valid;
      reason_type reason;
      logic       is_v6;
      logic [KEY_W-1:0] key_hi;
      logic [KEY_W-1:0] key_lo;
   } result_type;

endpackage

FILE: hdl/ipke_capture.sv
module ipke_capture (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [ipke_pkg::DATA_W-1:0]    data_byte,
   input  logic                           last_byte,
   input  logic                           addr_select,
   output ipke_pkg::pkt_view_type         view
);
   import ipke_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [VER_W-1:0]   version_ff, version_in;
   logic [COUNT_W-1:0] hdr_ff, hdr_in;
   logic [DATA_W-1:0]  addr_ff [ADDR_BYTES];
   logic [DATA_W-1:0]  addr_in [ADDR_BYTES];
   logic [COUNT_W-1:0] off;
   logic [COUNT_W-1:0] len;
   logic [COUNT_W-1:0] rel;
   logic               in_window;

   // address window of the selected field for the known version
   always_comb begin
      if (version_ff == VERSION_6) begin
         off = addr_select ? V6_DST_OFF : V6_SRC_OFF;
         len = V6_ADDR_LEN;
      end else begin
         off = addr_select ? V4_DST_OFF : V4_SRC_OFF;
         len = V4_ADDR_LEN;
      end
      rel = count_ff - off;
      in_window = (count_ff != '0) &&
                  ((version_ff == VERSION_4) || (version_ff == VERSION_6)) &&
                  (count_ff >= off) && (rel < len);
   end

   // next packet state
   always_comb begin
      version_in = version_ff;
      hdr_in     = hdr_ff;
      addr_in    = addr_ff;
      if (count_ff == '0) begin
         version_in = data_byte[7:4];
         hdr_in     = {data_byte[3:0], 2'b00};
      end else if (in_window) begin
         addr_in[rel[INDEX_W-1:0]] = data_byte;
      end
      count_in = (count_ff < COUNT_MAX) ? count_ff + 1'b1 : count_ff;
   end

   // view including the current word
   always_comb begin
      view.count     = count_in;
      view.version   = version_in;
      view.hdr_bytes = hdr_in;
      for (int i = 0; i < ADDR_BYTES; i++) begin
         view.addr[(ADDR_BYTES-1-i)*DATA_W +: DATA_W] = addr_in[i];
      end
   end

   // per-packet counters, cleared at the end of each packet
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         version_ff <= '0;
         hdr_ff     <= '0;
      end else if (step) begin
         if (last_byte) begin
            count_ff   <= '0;
            version_ff <= '0;
            hdr_ff     <= '0;
         end else begin
            count_ff   <= count_in;
            version_ff <= version_in;
            hdr_ff     <= hdr_in;
         end
      end
   end

   // address bytes, kept across packets
   always_ff @(posedge clock) begin
      if (step) begin
         addr_ff <= addr_in;
      end
   end

endmodule

FILE: hdl/ipke_judge.sv
module ipke_judge (
   input  ipke_pkg::pkt_view_type view,
   output ipke_pkg::result_type   result
);
   import ipke_pkg::*;

   logic [31:0]      v4_addr;
   logic [KEY_W-1:0] v6_hi;
   logic [KEY_W-1:0] v6_lo;

   assign v6_hi   = view.addr[2*KEY_W-1:KEY_W];
   assign v6_lo   = view.addr[KEY_W-1:0];
   assign v4_addr = view.addr[2*KEY_W-1 -: 32];

   // checks in priority order per version
   always_comb begin
      result.key_valid = 1'b0;
      result.reason    = REASON_OK;
      result.is_v6     = 1'b0;
      result.key_hi    = '0;
      result.key_lo    = '0;
      if (view.version == VERSION_4) begin
         if (view.count < V4_MIN_BYTES) begin
            result.reason = REASON_TOO_SHORT;
         end else if (view.hdr_bytes < V4_MIN_BYTES || view.hdr_bytes > view.count) begin
            result.reason = REASON_BAD_HDR_LEN;
         end else if (v4_addr == '0) begin
            result.reason = REASON_UNSPEC;
         end else if (v4_addr[31:28] == V4_MCAST_NIB) begin
            result.reason = REASON_MULTICAST;
         end else begin
            result.key_lo = {32'd0, v4_addr};
         end
      end else if (view.version == VERSION_6) begin
         if (view.count < V6_MIN_BYTES) begin
            result.reason = REASON_TOO_SHORT;
         end else if (v6_hi == '0 && v6_lo == '0) begin
            result.reason = REASON_UNSPEC;
         end else if (v6_hi[KEY_W-1 -: DATA_W] == V6_MCAST_BYTE) begin
            result.reason = REASON_MULTICAST;
         end else begin
            result.is_v6  = 1'b1;
            result.key_hi = v6_hi;
            result.key_lo = v6_lo;
         end
      end else begin
         result.reason = REASON_BAD_VERSION;
      end
      result.key_valid = (result.reason == REASON_OK);
   end

endmodule

FILE: hdl/ip_address_key_extractor.sv
// Path: a last word goes through the input register and then the result register to rsp.
// Throughput: one word per cycle; one input register and one result register, so req
// can take one more word while a result waits, and stalls only when both are held.
// Reset: synchronous, active high; clears valids, per-packet counters and addr_select.
// Address bytes are not reset; they are rewritten by every packet before use.
module ip_address_key_extractor (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // [63:0] key_hi, [127:64] key_lo
   output logic [4:0]   rsp_tuser,   // [0] key_valid, [3:1] reason, [4] is_v6
   input  logic         csr_wr_en,
   input  logic [0:0]   csr_wr_data  // [0] addr_select
);
   import ipke_pkg::*;

   logic              sel_ff;
   logic              in_valid_ff, in_valid_in;
   logic [DATA_W-1:0] in_data_ff;
   logic              in_last_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff;
   result_type        result;
   pkt_view_type      view;
   logic              advance;
   logic              step;
   logic              req_accept;

   // handshake
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign step       = in_valid_ff && advance;

   // address select register
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else if (csr_wr_en) begin
         sel_ff <= csr_wr_data[0];
      end
   end

   // input word register
   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   ipke_capture u_capture (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .data_byte   (in_data_ff),
      .last_byte   (in_last_ff),
      .addr_select (sel_ff),
      .view        (view)
   );

   ipke_judge u_judge (
      .view   (view),
      .result (result)
   );

   // result register
   always_comb begin
      if (step && in_last_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_last_ff) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.key_lo, out_ff.key_hi};
   assign rsp_tuser  = {out_ff.is_v6, out_ff.reason, out_ff.key_valid};

   // a fresh result comes only from a processed last word
   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff && in_last_ff))
      else $error("result without a last word");

   // a valid key always carries the ok reason
   a_valid_is_ok: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.key_valid) |-> (out_ff.reason == REASON_OK))
      else $error("valid key with failing reason");

   // a rejected packet gives an empty key
   a_reject_empty: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.key_valid) |->
         (out_ff.key_hi == '0 && out_ff.key_lo == '0 && !out_ff.is_v6))
      else $error("rejected packet with nonzero key");

   // a held result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !step)
      else $error("result overwritten while stalled");

endmodule
